>>> src/scrp_pkg.sv
// Shared types, constants and rounding helper for the sine/cosine pipeline.
package scrp_pkg;

  localparam int FW = 34;
  localparam int PW = 2 * FW;

  localparam logic [31:0] INVPI_Q32 = 32'h517CC1B7;
  localparam logic [7:0]  C1_NUM    = 8'd201;

  localparam logic [63:0] FIVE10 = 64'd9765625;
  localparam logic [63:0] FIVE12 = 64'd244140625;
  localparam logic [63:0] FIVE13 = 64'd1220703125;
  localparam logic [63:0] FIVE15 = 64'd30517578125;

  localparam logic [63:0] C2_A   = 64'd967653589793 << 24;
  localparam logic [63:0] C2_Q57 = ((C2_A / FIVE15) << 18)
                                 + ((((C2_A % FIVE15) << 18) + FIVE15 / 2) / FIVE15);
  localparam logic [22:0] C2_HI  = 23'(C2_Q57 >> 24);
  localparam logic [23:0] C2_LO  = C2_Q57[23:0];

  localparam logic [63:0] R1_MAG = ((64'd1666665668 << 21) + FIVE10 / 2) / FIVE10;
  localparam logic [63:0] R2_MAG = ((64'd8333025139 << 19) + FIVE12 / 2) / FIVE12;
  localparam logic [63:0] R3_MAG = ((64'd1980741872 << 18) + FIVE13 / 2) / FIVE13;
  localparam logic [63:0] R4_MAG = ((64'd2601903036 << 16) + FIVE15 / 2) / FIVE15;

  localparam logic signed [FW-1:0] R1_Q31 = -$signed(FW'(R1_MAG));
  localparam logic signed [FW-1:0] R2_Q31 =  $signed(FW'(R2_MAG));
  localparam logic signed [FW-1:0] R3_Q31 = -$signed(FW'(R3_MAG));
  localparam logic signed [FW-1:0] R4_Q31 =  $signed(FW'(R4_MAG));

  typedef struct packed {
    logic signed [FW-1:0] f;
    logic                 flip;
  } scrp_red_t;

  function automatic logic signed [FW-1:0] rnd31(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + (PW'(1) <<< 30);
    return FW'(s >>> 31);
  endfunction

endpackage

>>> src/scrp_if.sv
// Request and response channel interfaces of the sine/cosine block.
interface scrp_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] angle;

  modport source (output valid, output op, output angle, input ready);
  modport sink (input valid, input op, input angle, output ready);
endinterface

interface scrp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> src/scrp_reduce.sv
// Range reduction pipeline: quadrant count, exact C1 removal, C2 removal to Q31.
module scrp_reduce import scrp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               op,
  input  logic signed [31:0] angle,
  output logic               red_valid,
  input  logic               red_ready,
  output scrp_red_t          red
);

  localparam int NS    = 6;
  localparam int SH    = ANGLE_FRAC_BITS + 32;
  localparam int C1SH  = ANGLE_FRAC_BITS - 7;
  localparam int F58SH = 58 - ANGLE_FRAC_BITS;

  logic [NS-1:0] vld;
  logic [NS:0]   go;

  logic               op0, neg0, op1, neg1;
  logic [31:0]        mag0, mag1, mag2;
  logic [63:0]        prod1;
  logic [16:0]        xn2_2;
  logic               flip2, flip3, flip4, flip5;
  logic signed [35:0] d1_3, d1_4;
  logic [39:0]        c2hi3;
  logic [40:0]        c2lo3;
  logic [63:0]        c2p4;
  logic signed [FW-1:0] f5;

  logic signed [32:0] ang_ext;
  logic [63:0]        nsum;
  logic [15:0]        n_c;
  logic signed [47:0] d1_c;
  logic signed [63:0] f58_c;

  assign go[NS] = red_ready;
  for (genvar k = 0; k < NS; k++) begin : g_go
    assign go[k] = !vld[k] || go[k+1];
  end
  assign req_ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) begin
          vld[k] <= (k == 0) ? req_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_comb begin
    ang_ext = {angle[31], angle};
    nsum    = prod1 + (op1 ? (64'd1 << SH) : (64'd1 << (SH - 1)));
    n_c     = 16'(nsum >> SH);
    d1_c    = $signed({16'd0, mag2})
            - $signed((48'(xn2_2) * 48'(C1_NUM)) << C1SH);
    f58_c   = (64'(d1_4) <<< F58SH) - $signed(c2p4) + (64'sd1 <<< 26);
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      op0  <= op;
      neg0 <= angle[31];
      mag0 <= 32'(angle[31] ? -ang_ext : ang_ext);
    end
    if (go[1]) begin
      op1   <= op0;
      neg1  <= neg0;
      mag1  <= mag0;
      prod1 <= 64'(mag0) * 64'(INVPI_Q32);
    end
    if (go[2]) begin
      mag2  <= mag1;
      xn2_2 <= op1 ? ({n_c, 1'b0} - 17'd1) : {n_c, 1'b0};
      flip2 <= n_c[0] ^ (!op1 && neg1);
    end
    if (go[3]) begin
      d1_3  <= 36'(d1_c);
      c2hi3 <= 40'(xn2_2) * 40'(C2_HI);
      c2lo3 <= 41'(xn2_2) * 41'(C2_LO);
      flip3 <= flip2;
    end
    if (go[4]) begin
      d1_4  <= d1_3;
      c2p4  <= (64'(c2hi3) << 24) + 64'(c2lo3);
      flip4 <= flip3;
    end
    if (go[5]) begin
      f5    <= FW'(f58_c >>> 27);
      flip5 <= flip4;
    end
  end

  assign red_valid = vld[NS-1];
  assign red       = '{f: f5, flip: flip5};

endmodule

>>> src/scrp_poly.sv
// Polynomial pipeline: square, Horner chain, final rounding, saturation and sign.
module scrp_poly import scrp_pkg::*; #(
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               red_valid,
  output logic               red_ready,
  input  scrp_red_t          red,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic signed [31:0] value
);

  localparam int NS = 15;
  localparam int RS = 31 - RESULT_FRAC_BITS;
  localparam int RW = FW + 1;

  logic [NS-1:0] vld;
  logic [NS:0]   go;

  logic signed [FW-1:0] f_p    [0:11];
  logic                 flip_p [0:NS-2];
  logic [32:0]          g_p    [2:8];

  logic [32:0]          af0;
  logic [63:0]          sq1;
  logic signed [PW-1:0] m3, m5, m7, m9, m11;
  logic signed [FW-1:0] t4, t6, t8, t10;
  logic signed [RW-1:0] res12, sat13;

  logic signed [FW-1:0] gs3, gs5, gs7, gs9;
  logic signed [RW-1:0] rr_c, lim_c;

  assign go[NS] = rsp_ready;
  for (genvar k = 0; k < NS; k++) begin : g_go
    assign go[k] = !vld[k] || go[k+1];
  end
  assign red_ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (go[k]) begin
          vld[k] <= (k == 0) ? red_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_comb begin
    gs3   = $signed({1'b0, g_p[2]});
    gs5   = $signed({1'b0, g_p[4]});
    gs7   = $signed({1'b0, g_p[6]});
    gs9   = $signed({1'b0, g_p[8]});
    rr_c  = (res12 + (RW'(1) <<< (RS - 1))) >>> RS;
    lim_c = RW'(1) <<< RESULT_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      f_p[0]    <= red.f;
      flip_p[0] <= red.flip;
      af0       <= 33'(red.f < 0 ? -red.f : red.f);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (go[k]) begin
        flip_p[k] <= flip_p[k-1];
      end
    end
    for (int k = 1; k < 12; k++) begin
      if (go[k]) begin
        f_p[k] <= f_p[k-1];
      end
    end
    for (int k = 3; k < 9; k++) begin
      if (go[k]) begin
        g_p[k] <= g_p[k-1];
      end
    end
    if (go[1]) begin
      sq1 <= 64'(af0) * 64'(af0);
    end
    if (go[2]) begin
      g_p[2] <= 33'((sq1 + (64'd1 << 30)) >> 31);
    end
    if (go[3]) begin
      m3 <= PW'(R4_Q31) * PW'(gs3);
    end
    if (go[4]) begin
      t4 <= rnd31(m3) + R3_Q31;
    end
    if (go[5]) begin
      m5 <= PW'(t4) * PW'(gs5);
    end
    if (go[6]) begin
      t6 <= rnd31(m5) + R2_Q31;
    end
    if (go[7]) begin
      m7 <= PW'(t6) * PW'(gs7);
    end
    if (go[8]) begin
      t8 <= rnd31(m7) + R1_Q31;
    end
    if (go[9]) begin
      m9 <= PW'(t8) * PW'(gs9);
    end
    if (go[10]) begin
      t10 <= rnd31(m9);
    end
    if (go[11]) begin
      m11 <= PW'(f_p[10]) * PW'(t10);
    end
    if (go[12]) begin
      res12 <= RW'(f_p[11]) + RW'(rnd31(m11));
    end
    if (go[13]) begin
      if (rr_c > lim_c) begin
        sat13 <= lim_c;
      end else if (rr_c < -lim_c) begin
        sat13 <= -lim_c;
      end else begin
        sat13 <= rr_c;
      end
    end
    if (go[14]) begin
      value <= 32'(flip_p[13] ? -sat13 : sat13);
    end
  end

  assign rsp_valid = vld[NS-1];

endmodule

>>> src/sine_cosine_range_reduced_poly.sv
// Top level of the fixed-point sine/cosine block.
//
// Usage: a request on req carries op (0 sine, 1 cosine) and a signed angle in
// radians with ANGLE_FRAC_BITS fraction bits. Each request gives exactly one
// response on rsp: the signed result with RESULT_FRAC_BITS fraction bits,
// saturated to plus or minus one.
// Pipeline: a request passes through 6 register stages of range reduction and
// 15 of polynomial before its response is valid.
// Throughput: one request per cycle unless a low rsp.ready stalls the pipeline,
// set by the fully pipelined multiply chain; every stage holds its own valid bit.
// Reset: rst clears all valid bits; no response is pending afterwards.
// Stall: when rsp.ready is low the last stage holds its result; earlier
// stages keep advancing into empty slots, so req.ready drops only once every
// stage holds a request.
module sine_cosine_range_reduced_poly import scrp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS  = 24,
  parameter int RESULT_FRAC_BITS = 30
) (
  input logic        clk,
  input logic        rst,
  scrp_req_if.sink   req,
  scrp_rsp_if.source rsp
);

  logic      red_valid;
  logic      red_ready;
  scrp_red_t red;

  scrp_reduce #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .op        (req.op),
    .angle     (req.angle),
    .red_valid (red_valid),
    .red_ready (red_ready),
    .red       (red)
  );

  scrp_poly #(
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_poly (
    .clk       (clk),
    .rst       (rst),
    .red_valid (red_valid),
    .red_ready (red_ready),
    .red       (red),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .value     (rsp.value)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the fixed-point sine/cosine pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FB  = 24;
  localparam int RESULT_FB = 30;
  localparam int PIPE_LATENCY = 20;

  localparam int PI_2_Q24    = 26353589;
  localparam int PI_Q24      = 52707179;
  localparam int PI_3_2_Q24  = 79060768;
  localparam int FOUR_PI_Q24 = 210828714;

  localparam longint unsigned RECIP_PI_Q32 = 64'h517CC1B7;
  localparam longint          PI_HI_NUMER  = 201;
  localparam longint unsigned POW5_10      = 64'd9765625;
  localparam longint unsigned POW5_12      = 64'd244140625;
  localparam longint unsigned POW5_13      = 64'd1220703125;
  localparam longint unsigned POW5_15      = 64'd30517578125;
  localparam longint unsigned PI_LO_SCALED = 64'd967653589793 << 24;
  localparam longint PI_LO_Q57 = longint'(((PI_LO_SCALED / POW5_15) << 18)
      + ((((PI_LO_SCALED % POW5_15) << 18) + POW5_15 / 2) / POW5_15));
  localparam longint COEF_G1 = -longint'(((64'd1666665668 << 21) + POW5_10 / 2) / POW5_10);
  localparam longint COEF_G2 = longint'(((64'd8333025139 << 19) + POW5_12 / 2) / POW5_12);
  localparam longint COEF_G3 = -longint'(((64'd1980741872 << 18) + POW5_13 / 2) / POW5_13);
  localparam longint COEF_G4 = longint'(((64'd2601903036 << 16) + POW5_15 / 2) / POW5_15);

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } trig_op_e;

  typedef struct {
    trig_op_e           op;
    logic signed [31:0] angle;
  } angle_req_t;

  typedef struct {
    trig_op_e           op;
    logic signed [31:0] angle;
    logic signed [31:0] value;
  } sincos_expect_t;

  logic clk;
  logic rst;

  scrp_req_if req_ch();
  scrp_rsp_if rsp_ch();

  sine_cosine_range_reduced_poly #(
    .ANGLE_FRAC_BITS (ANGLE_FB),
    .RESULT_FRAC_BITS(RESULT_FB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  angle_req_t     pending_reqs[$];
  sincos_expect_t expected_values[$];
  int             reqs_queued = 0;
  int             reqs_taken = 0;
  int             values_checked = 0;
  int             failures = 0;
  int             directed_count = 0;
  logic           req_fire = 1'b0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             rx_cycles = 0;
  int             holdoff_left = 0;
  int             holdoff_done = 0;
  int             seg_left = 0;
  int             rx_mode = 0;

  function automatic longint round_half_up(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sincos_expected(input trig_op_e op,
                                                         input logic signed [31:0] angle);
    longint unsigned mag;
    longint unsigned quot;
    longint unsigned nq;
    longint unsigned abs_red;
    longint          xn2;
    longint          red_hi;
    longint          red58;
    longint          red31;
    longint          g;
    longint          t;
    longint          res;
    longint          lim;
    logic            flip;
    mag  = angle[31] ? (64'h1_0000_0000 - {32'h0, angle}) : {32'h0, angle};
    quot = mag * RECIP_PI_Q32;
    nq   = (quot + ((op == OP_COSINE) ? (64'd1 << (ANGLE_FB + 32))
                                      : (64'd1 << (ANGLE_FB + 31)))) >> (ANGLE_FB + 32);
    xn2  = (op == OP_COSINE) ? longint'(2 * nq) - 1 : longint'(2 * nq);
    red_hi = longint'(mag) - PI_HI_NUMER * xn2 * (longint'(1) << (ANGLE_FB - 7));
    red58  = red_hi * (longint'(1) << (58 - ANGLE_FB));
    red58  = red58 - xn2 * PI_LO_Q57;
    red31  = round_half_up(red58, 27);
    abs_red = (red31 < 0) ? longint'(-red31) : longint'(red31);
    g = longint'((abs_red * abs_red + (64'd1 << 30)) >> 31);
    t = COEF_G4;
    t = round_half_up(t * g, 31) + COEF_G3;
    t = round_half_up(t * g, 31) + COEF_G2;
    t = round_half_up(t * g, 31) + COEF_G1;
    t = round_half_up(t * g, 31);
    res = red31 + round_half_up(red31 * t, 31);
    if (RESULT_FB < 31) begin
      res = round_half_up(res, 31 - RESULT_FB);
    end
    lim = longint'(1) << RESULT_FB;
    if (res > lim) begin
      res = lim;
    end
    if (res < -lim) begin
      res = -lim;
    end
    flip = nq[0];
    if (op == OP_SINE && angle[31]) begin
      flip = !flip;
    end
    if (flip) begin
      res = -res;
    end
    return res[31:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_SINE;
    req_ch.angle = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // sample both channels
  always @(posedge clk) begin
    req_fire = !rst && req_ch.valid && req_ch.ready;
    if (req_fire) begin
      reqs_taken++;
      expected_values.push_back('{trig_op_e'(req_ch.op), req_ch.angle,
                                  sincos_expected(trig_op_e'(req_ch.op), req_ch.angle)});
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_values.size() == 0) begin
        $error("unexpected response: value actual %0d", rsp_ch.value);
        failures++;
      end else begin
        if (rsp_ch.value !== expected_values[0].value) begin
          $error("value mismatch (op %s angle %0d): expected %0d actual %0d",
                 expected_values[0].op.name(), expected_values[0].angle,
                 expected_values[0].value, rsp_ch.value);
          failures++;
        end
        values_checked++;
        expected_values.delete(0);
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_fire) begin
        pending_reqs.delete(0);
      end
      if (req_ch.valid && !req_fire) begin
        // hold the offered request
      end else if (gap_left > 0 && holdoff_left == 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.op <= pending_reqs[0].op;
        req_ch.angle <= pending_reqs[0].angle;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response stall pattern
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (holdoff_left == 0 && (rx_cycles == 400 || rx_cycles == 1300)) begin
        holdoff_left = 90;
        holdoff_done++;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(16, 160);
          rx_mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (rx_mode)
          0: begin
            rsp_ch.ready <= 1'b1;
          end
          1: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_ch.ready <= (rx_cycles % 5) != 0;
          end
          default: begin
            rsp_ch.ready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int             directed_angles[$];
    angle_req_t     item;
    int             base;
    int             kind;
    directed_angles = '{0, 1, -1, 32'sh7FFFFFFF, 32'sh80000000, PI_2_Q24, -PI_2_Q24,
                        PI_2_Q24 + 1, PI_Q24, -PI_Q24, PI_3_2_Q24};
    @(negedge rst);
    foreach (directed_angles[i]) begin
      pending_reqs.push_back('{OP_SINE, directed_angles[i]});
      pending_reqs.push_back('{OP_COSINE, directed_angles[i]});
    end
    directed_count = pending_reqs.size();
    reqs_queued += directed_count;
    while (reqs_taken < reqs_queued) @(posedge clk);

    for (int i = 0; i < 680; i++) begin
      item.op = trig_op_e'($urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        item.angle = $urandom();
      end else if (kind < 7) begin
        item.angle = int'($urandom_range(0, 2 * FOUR_PI_Q24)) - FOUR_PI_Q24;
      end else if (kind < 9) begin
        base = int'($urandom_range(0, 81)) * PI_2_Q24 + int'($urandom_range(0, 511)) - 256;
        item.angle = $urandom_range(0, 1) ? -base : base;
      end else begin
        base = $urandom_range(0, 4095);
        item.angle = $urandom_range(0, 1) ? (32'sh80000000 + base) : (32'sh7FFFFFFF - base);
      end
      pending_reqs.push_back(item);
    end
    reqs_queued += 680;

    while (reqs_taken < reqs_queued) @(posedge clk);
    while (expected_values.size() > 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("Checked %0d of %0d sine/cosine requests (%0d directed, rest random), %0d failures.",
             values_checked, reqs_queued, directed_count, failures);
    $display("Receiver held off %0d times with the pipeline full.", holdoff_done);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Regression FAIL");
    $finish;
  end

endmodule
